[rtl/cpsm_pkg.sv]
// Package for the column projection segment merger.
// Holds the field widths, register indexes and the result record type.
// No dependencies.
`default_nettype none

package cpsm_pkg;

    // Column index and count widths are fixed by the field definitions.
    localparam int COL_W   = 11;
    localparam int CNT_W   = 11;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 8;
    localparam int CDATA_W = 16;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_START_COUNT_MIN  = 8'd0;
    localparam logic [CIDX_W-1:0] REG_LONG_WIDTH_LIMIT = 8'd1;
    localparam logic [CIDX_W-1:0] REG_MERGE_GAP_MAX    = 8'd2;
    localparam logic [CIDX_W-1:0] REG_MERGE_SPAN_LIMIT = 8'd3;

    // Register reset values.
    localparam logic [CFG_W-1:0] START_COUNT_MIN_RST  = 11'd1;
    localparam logic [CFG_W-1:0] LONG_WIDTH_LIMIT_RST = 11'd12;
    localparam logic [CFG_W-1:0] MERGE_GAP_MAX_RST    = 11'd6;
    localparam logic [CFG_W-1:0] MERGE_SPAN_LIMIT_RST = 11'd30;

    // One result record as held in the output queue.
    typedef struct packed {
        logic             last;
        logic             no_segment;
        logic [COL_W-1:0] seg_end;
        logic [COL_W-1:0] seg_start;
    } seg_result_t;

endpackage

`default_nettype wire

[rtl/column_projection_segment_merger.sv]
// Top level of the column projection segment merger.
// Depends on cpsm_pkg for widths, register indexes and the result record.
//
//  Channel   Direction  Ports                               Contents
//  s_        in         s_tvalid s_tready s_tdata s_tlast   one column count per request
//  m_        out        m_tvalid m_tready m_tdata m_tuser   one segment per request
//                       m_tlast
//  cfg_      in         cfg_valid cfg_ready cfg_index       register writes
//                       cfg_data
//
// Each column is processed in the cycle it is accepted; one column per cycle while s_tready is high.
// A column produces zero, one or two results, which go into a four-entry
// output queue; s_tready is high while the queue has room for two results,
// so a stalled output throttles the input only once more than two results wait.
// The queue drains one result per cycle while m_tready is high. aresetn is synchronous and active low;
// cfg_ready is always high.
`default_nettype none

module column_projection_segment_merger (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [10:0] column_count, [15:11] zero
    input  wire logic        s_tlast,   // last_column
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [10:0] seg_start, [21:11] seg_end, [23:22] zero
    output logic             m_tuser,   // [0] no_segment
    output logic             m_tlast,   // last
    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [cpsm_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [cpsm_pkg::CDATA_W-1:0] cfg_data
);

    localparam int COL_W = cpsm_pkg::COL_W;
    localparam int CFG_W = cpsm_pkg::CFG_W;

    // Configuration registers.
    logic [CFG_W-1:0] start_min_reg, long_lim_reg, gap_max_reg, span_lim_reg;

    // Scan state.
    logic [COL_W-1:0] col_reg, col_next;
    logic             run_open_reg, run_open_next;
    logic [COL_W-1:0] run_begin_reg, run_begin_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [COL_W-1:0] pend_begin_reg, pend_begin_next;
    logic [COL_W-1:0] pend_finish_reg, pend_finish_next;

    // Output queue.
    cpsm_pkg::seg_result_t q_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg;

    logic              in_fire, out_fire;
    logic [cpsm_pkg::CNT_W-1:0] count;
    logic              opens, closes, merge, emit_prev;
    logic [COL_W-1:0]  run_end;
    logic signed [12:0] width_s, gap_s, span_s;
    logic              push0, push1;
    cpsm_pkg::seg_result_t res_prev, res_final, slot0;
    logic [1:0]        n_push;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign count     = s_tdata[cpsm_pkg::CNT_W-1:0];

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_min_reg <= cpsm_pkg::START_COUNT_MIN_RST;
            long_lim_reg  <= cpsm_pkg::LONG_WIDTH_LIMIT_RST;
            gap_max_reg   <= cpsm_pkg::MERGE_GAP_MAX_RST;
            span_lim_reg  <= cpsm_pkg::MERGE_SPAN_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                cpsm_pkg::REG_START_COUNT_MIN:  start_min_reg <= cfg_data[CFG_W-1:0];
                cpsm_pkg::REG_LONG_WIDTH_LIMIT: long_lim_reg  <= cfg_data[CFG_W-1:0];
                cpsm_pkg::REG_MERGE_GAP_MAX:    gap_max_reg   <= cfg_data[CFG_W-1:0];
                cpsm_pkg::REG_MERGE_SPAN_LIMIT: span_lim_reg  <= cfg_data[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Run detection and the merge decision for a run closing on this column.
    always_comb begin
        opens   = count > start_min_reg;
        closes  = (count == 11'd0) && run_open_reg;
        run_end = col_reg - 1'b1;
        width_s = $signed({2'b00, run_end}) - $signed({2'b00, run_begin_reg});
        gap_s   = $signed({2'b00, run_begin_reg}) - $signed({2'b00, pend_finish_reg});
        span_s  = $signed({2'b00, run_end}) - $signed({2'b00, pend_begin_reg});
        merge   = pend_valid_reg
                  && (width_s <= $signed({2'b00, long_lim_reg}))
                  && (gap_s <= $signed({2'b00, gap_max_reg}))
                  && (span_s < $signed({2'b00, span_lim_reg}));
        emit_prev = closes && !merge && pend_valid_reg;
    end

    // Next scan state and the results this column produces.
    always_comb begin
        col_next         = col_reg + 1'b1;
        run_open_next    = run_open_reg;
        run_begin_next   = run_begin_reg;
        pend_valid_next  = pend_valid_reg;
        pend_begin_next  = pend_begin_reg;
        pend_finish_next = pend_finish_reg;

        if (opens) begin
            if (!run_open_reg) begin
                run_open_next  = 1'b1;
                run_begin_next = col_reg;
            end
        end else if (closes) begin
            run_open_next = 1'b0;
            if (merge) begin
                pend_finish_next = run_end;
            end else begin
                pend_valid_next  = 1'b1;
                pend_begin_next  = run_begin_reg;
                pend_finish_next = run_end;
            end
        end

        res_prev.seg_start  = pend_begin_reg;
        res_prev.seg_end    = pend_finish_reg;
        res_prev.no_segment = 1'b0;
        res_prev.last       = 1'b0;

        // Final result of the frame, taken after the closing run is handled.
        if (pend_valid_next) begin
            res_final.seg_start  = pend_begin_next;
            res_final.seg_end    = pend_finish_next;
            res_final.no_segment = 1'b0;
        end else begin
            res_final.seg_start  = '0;
            res_final.seg_end    = '0;
            res_final.no_segment = 1'b1;
        end
        res_final.last = 1'b1;

        // The last column returns all scan state to its reset value.
        if (s_tlast) begin
            col_next         = '0;
            run_open_next    = 1'b0;
            run_begin_next   = '0;
            pend_valid_next  = 1'b0;
            pend_begin_next  = '0;
            pend_finish_next = '0;
        end

        push0  = in_fire && (emit_prev || s_tlast);
        push1  = in_fire && emit_prev && s_tlast;
        slot0  = emit_prev ? res_prev : res_final;
        n_push = {1'b0, push0} + {1'b0, push1};
    end

    // Scan state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg         <= '0;
            run_open_reg    <= 1'b0;
            run_begin_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            pend_begin_reg  <= '0;
            pend_finish_reg <= '0;
        end else if (in_fire) begin
            col_reg         <= col_next;
            run_open_reg    <= run_open_next;
            run_begin_reg   <= run_begin_next;
            pend_valid_reg  <= pend_valid_next;
            pend_begin_reg  <= pend_begin_next;
            pend_finish_reg <= pend_finish_next;
        end
    end

    // Output queue storage.
    always_ff @(posedge aclk) begin
        if (push0) begin
            q_reg[wr_ptr_reg] <= slot0;
        end
        if (push1) begin
            q_reg[wr_ptr_reg + 2'd1] <= res_final;
        end
    end

    // Output queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + n_push;
            if (out_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {1'b0, n_push} - {2'b00, out_fire};
        end
    end

    // Handshake and output packing.
    assign s_tready = cnt_reg <= 3'd2;
    assign m_tvalid = cnt_reg != 3'd0;
    assign m_tdata  = {2'b00, q_reg[rd_ptr_reg].seg_end, q_reg[rd_ptr_reg].seg_start};
    assign m_tuser  = q_reg[rd_ptr_reg].no_segment;
    assign m_tlast  = q_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire

[sim/tb_column_projection_segment_merger.sv]
// Testbench for column_projection_segment_merger: streams frames of column counts,
// predicts the merged segments per column and checks every result request.
// Depends on cpsm_pkg and the top level in rtl/.
`timescale 1ns / 100ps

module tb_column_projection_segment_merger;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int REG_COUNT     = 4;
    localparam logic [10:0] COUNT_MAX = 11'd1024;

    // Results that can be read straight off the frame.
    localparam cpsm_pkg::seg_result_t SEG_NONE =
        '{last: 1'b1, no_segment: 1'b1, seg_end: 11'd0, seg_start: 11'd0};
    localparam cpsm_pkg::seg_result_t SEG_FIRST_COL =
        '{last: 1'b1, no_segment: 1'b0, seg_end: 11'd0, seg_start: 11'd0};
    localparam cpsm_pkg::seg_result_t SEG_UNTYPED = '0;

    // One row of the directed table.
    typedef struct packed {
        logic [10:0]           count;
        logic                  last;
        logic                  typed;
        cpsm_pkg::seg_result_t want;
    } col_req_t;

    // Directed frames under the reset register values.
    localparam col_req_t DIRECTED [0:21] = '{
        '{11'd0,    1'b1, 1'b1, SEG_NONE},      // empty one-column frame
        '{11'd1024, 1'b1, 1'b1, SEG_NONE},      // run opened on the last column is dropped
        '{11'd2,    1'b0, 1'b0, SEG_UNTYPED},   // opens a run at column 0
        '{11'd1,    1'b0, 1'b0, SEG_UNTYPED},   // at the threshold: no effect
        '{11'd0,    1'b0, 1'b0, SEG_UNTYPED},   // first short run starts a segment
        '{11'd1,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd1023, 1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b0, 1'b0, SEG_UNTYPED},   // merges into the pending segment
        '{11'd3,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd5,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b0, 1'b0, SEG_UNTYPED},   // gap too wide: previous segment goes out
        '{11'd9,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b1, 1'b0, SEG_UNTYPED},   // run closes on the last column, then flush
        '{11'd4,    1'b0, 1'b0, SEG_UNTYPED},
        '{11'd0,    1'b1, 1'b1, SEG_FIRST_COL},
        '{11'd1,    1'b1, 1'b1, SEG_NONE}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    column_projection_segment_merger dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Register copies and segment state of the predictor.
    logic [10:0] cur_start = cpsm_pkg::START_COUNT_MIN_RST;
    logic [10:0] cur_long  = cpsm_pkg::LONG_WIDTH_LIMIT_RST;
    logic [10:0] cur_gap   = cpsm_pkg::MERGE_GAP_MAX_RST;
    logic [10:0] cur_span  = cpsm_pkg::MERGE_SPAN_LIMIT_RST;
    logic [10:0] col_idx      = '0;
    bit          run_open     = 1'b0;
    logic [10:0] run_first    = '0;
    bit          seg_pending  = 1'b0;
    logic [10:0] pend_first   = '0;
    logic [10:0] pend_final   = '0;

    cpsm_pkg::seg_result_t expected_segments [$];

    int errors         = 0;
    int columns_sent   = 0;
    int frames_sent    = 0;
    int frame_pos      = 0;
    int segments_seen  = 0;
    int reg_settings   = 1;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;

    function automatic cpsm_pkg::seg_result_t make_seg(input logic [10:0] first,
                                                       input logic [10:0] final_col,
                                                       input logic none, input logic lst);
        cpsm_pkg::seg_result_t r;
        r.seg_start  = first;
        r.seg_end    = final_col;
        r.no_segment = none;
        r.last       = lst;
        return r;
    endfunction

    // Append one segment to the end of the expected list.
    task automatic expect_segment(input cpsm_pkg::seg_result_t seg);
        expected_segments.insert(expected_segments.size(), seg);
    endtask

    // A run [first, final_col] has closed: merge it or start a new segment.
    task automatic close_run(input logic [10:0] first, input logic [10:0] final_col,
                             input bit keep);
        int width;
        int gap;
        int span;
        bit merge_ok;
        width    = int'(final_col) - int'(first);
        merge_ok = 1'b0;
        if (width <= int'(cur_long) && seg_pending) begin
            gap      = int'(first) - int'(pend_final);
            span     = int'(final_col) - int'(pend_first);
            merge_ok = (gap <= int'(cur_gap)) && (span < int'(cur_span));
        end
        if (merge_ok) begin
            pend_final = final_col;
        end else begin
            if (seg_pending && keep)
                expect_segment(make_seg(pend_first, pend_final, 1'b0, 1'b0));
            seg_pending = 1'b1;
            pend_first  = first;
            pend_final  = final_col;
        end
    endtask

    // Advance the predictor by one accepted column.
    task automatic predict_column(input logic [10:0] count, input bit last, input bit keep);
        if (count > cur_start) begin
            if (!run_open) begin
                run_open  = 1'b1;
                run_first = col_idx;
            end
        end else if (count == 11'd0 && run_open) begin
            run_open = 1'b0;
            close_run(run_first, col_idx - 11'd1, keep);
        end
        if (last) begin
            if (keep)
                expect_segment(seg_pending ?
                    make_seg(pend_first, pend_final, 1'b0, 1'b1) : SEG_NONE);
            col_idx     = '0;
            run_open    = 1'b0;
            run_first   = '0;
            seg_pending = 1'b0;
            pend_first  = '0;
            pend_final  = '0;
        end else begin
            col_idx = col_idx + 11'd1;
        end
    endtask

    // Offer one column request and wait for it to be taken.
    task automatic send_column(input logic [10:0] count, input bit last,
                               input bit typed = 1'b0,
                               input cpsm_pkg::seg_result_t want = '0);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, count};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        predict_column(count, last, !typed);
        if (typed)
            expect_segment(want);
        columns_sent++;
        if (last) begin
            frames_sent++;
            frame_pos = 0;
        end else begin
            frame_pos++;
        end
    endtask

    // A count that opens a run under the current threshold, when one exists.
    function automatic logic [10:0] open_count();
        int pick;
        pick = $urandom_range(0, 9);
        if (cur_start >= COUNT_MAX || pick == 0)
            return COUNT_MAX;
        if (pick == 1 && cur_start < 11'd1023)
            return 11'd1023;
        return 11'($urandom_range(int'(cur_start) + 1, int'(COUNT_MAX)));
    endfunction

    // A nonzero count at or below the threshold; any count when there is none.
    function automatic logic [10:0] noise_count();
        if (cur_start == 11'd0)
            return 11'($urandom_range(0, int'(COUNT_MAX)));
        return 11'($urandom_range(1, cur_start < COUNT_MAX ? int'(cur_start)
                                                           : int'(COUNT_MAX)));
    endfunction

    // One stretch of a frame: a run, a gap, threshold noise or garbage.
    task automatic send_piece();
        int kind;
        int n;
        int cap;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            cap = (cur_long < 11'd30) ? int'(cur_long) + 3 : 32;
            n   = $urandom_range(1, cap);
            repeat (n) send_column(open_count(), 1'b0);
        end else if (kind < 80) begin
            cap = (cur_gap < 11'd16) ? int'(cur_gap) + 4 : 20;
            n   = $urandom_range(1, cap);
            repeat (n) send_column(11'd0, 1'b0);
        end else if (kind < 92) begin
            repeat ($urandom_range(1, 3)) send_column(noise_count(), 1'b0);
        end else begin
            repeat ($urandom_range(1, 4))
                send_column($urandom_range(0, 1) ? 11'd0
                            : 11'($urandom_range(0, int'(COUNT_MAX))), 1'b0);
        end
    endtask

    task automatic send_frame(input int len);
        int pick;
        while (frame_pos + 1 < len) send_piece();
        pick = $urandom_range(0, 2);
        send_column(pick == 0 ? 11'd0 : (pick == 1 ? open_count() : noise_count()), 1'b1);
    endtask

    // Random frames, mostly short, until the column budget is used.
    task automatic run_phase(input int n_cols);
        int goal;
        goal = columns_sent + n_cols;
        while (columns_sent < goal)
            send_frame($urandom_range(0, 9) == 0 ? $urandom_range(1, 250)
                                                 : $urandom_range(1, 50));
    endtask

    // Stop offering and wait until every expected segment has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_segments.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= {5'($urandom), value};
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            cpsm_pkg::REG_START_COUNT_MIN:  cur_start = value;
            cpsm_pkg::REG_LONG_WIDTH_LIMIT: cur_long  = value;
            cpsm_pkg::REG_MERGE_GAP_MAX:    cur_gap   = value;
            cpsm_pkg::REG_MERGE_SPAN_LIMIT: cur_span  = value;
            default: ;
        endcase
    endtask

    // Program all four registers plus one write to an unused index.
    task automatic program_regs(input logic [10:0] start_min, input logic [10:0] long_lim,
                                input logic [10:0] gap_max, input logic [10:0] span_lim);
        settle();
        write_reg(cpsm_pkg::REG_START_COUNT_MIN, start_min);
        write_reg(cpsm_pkg::REG_LONG_WIDTH_LIMIT, long_lim);
        write_reg(cpsm_pkg::REG_MERGE_GAP_MAX, gap_max);
        write_reg(cpsm_pkg::REG_MERGE_SPAN_LIMIT, span_lim);
        write_reg(8'($urandom_range(REG_COUNT, 255)), 11'($urandom));
        cfg_valid <= 1'b0;
        reg_settings++;
        @(posedge aclk);
    endtask

    // Result side: random stall bursts, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
            stall_left = $urandom_range(1, 9) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result request with the oldest expected segment.
    always @(posedge aclk) begin
        cpsm_pkg::seg_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            segments_seen++;
            if (expected_segments.size() == 0) begin
                $error("unexpected result: seg_start %0d seg_end %0d no_segment %0b last %0b",
                       m_tdata[10:0], m_tdata[21:11], m_tuser, m_tlast);
                errors++;
            end else begin
                want = expected_segments.pop_front();
                if (m_tdata[10:0] !== want.seg_start) begin
                    $error("seg_start: expected %0d, got %0d", want.seg_start, m_tdata[10:0]);
                    errors++;
                end
                if (m_tdata[21:11] !== want.seg_end) begin
                    $error("seg_end: expected %0d, got %0d", want.seg_end, m_tdata[21:11]);
                    errors++;
                end
                if (m_tuser !== want.no_segment) begin
                    $error("no_segment: expected %0b, got %0b", want.no_segment, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles where no request of any kind is accepted.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d idle cycles, %0d segments still expected.",
                     quiet_cycles, expected_segments.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames on the reset register values.
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        foreach (DIRECTED[i])
            send_column(DIRECTED[i].count, DIRECTED[i].last, DIRECTED[i].typed,
                        DIRECTED[i].want);

        // Long result hold-off with the sender pushing, then a full drain.
        settle();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 1'b1;
        run_phase(120);
        settle();
        tx_idle_pct = 15;
        rx_idle_pct = 15;
        run_phase(130);

        // Register extremes.
        program_regs(11'd0, 11'd0, 11'd0, 11'd0);
        run_phase(150);
        program_regs(COUNT_MAX, 11'd2047, 11'd2047, 11'd2047);
        run_phase(100);
        program_regs(11'd0, 11'd2047, 11'd2047, 11'd2047);
        run_phase(100);

        // Random settings with varied idling.
        repeat (5) begin
            program_regs(11'($urandom_range(0, 12)), 11'($urandom_range(0, 40)),
                         11'($urandom_range(0, 20)), 11'($urandom_range(0, 80)));
            tx_idle_pct = 12 * $urandom_range(0, 3);
            rx_idle_pct = 12 * $urandom_range(0, 3);
            run_phase(140);
        end

        // Closing stretch at full rate.
        program_regs(11'($urandom_range(0, 12)), 11'($urandom_range(0, 40)),
                     11'($urandom_range(0, 20)), 11'($urandom_range(0, 80)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(150);

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_segments.size() != 0) begin
            $error("%0d expected segments never arrived", expected_segments.size());
            errors++;
        end
        $display("Sent %0d columns in %0d frames under %0d register settings.",
                 columns_sent, frames_sent, reg_settings);
        $display("Checked %0d segment results, %0d mismatches.", segments_seen, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
